FILE: rtl/cvr_pkg.sv
// ----------------------------------------------------------------------------
// cvr_pkg
// Shared constants, CORDIC arctangent table and the word passed between the
// cells of the collision velocity response unit.
// ----------------------------------------------------------------------------
package cvr_pkg;

    // Q15.16 velocities; the arithmetic itself does not depend on it
    localparam int FRAC_BITS    = 16;
    // Phase width of the contact angle (one turn = 2^ANGLE_BITS)
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 30;
    // Cells plus response stages: edges from the accepting edge to the
    // edge that takes the result
    localparam int LATENCY      = CORDIC_STEPS + 8;

    // CORDIC gain compensation in Q2.30
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    // Restitution register
    localparam logic [16:0] RESTITUTION_RESET = 17'd65536;
    localparam logic [16:0] RESTITUTION_MAX   = 17'd65536;

    // atan(2^-i) on a 2^32-per-turn phase
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Word handed from cell to cell: one CORDIC step and one quotient bit each
    typedef struct packed {
        logic               valid;
        logic [1:0]         quad;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [62:0]        rem;
        logic [32:0]        dvsr;
        logic [29:0]        quo;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_cell_word;

endpackage

FILE: rtl/cvr_cell.sv
// ----------------------------------------------------------------------------
// cvr_cell
// One link of the chain: a CORDIC rotation step and one restoring division
// step on the mass ratio, registered towards the next cell.
// ----------------------------------------------------------------------------
module cvr_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_step,
    input  cvr_pkg::t_cell_word i_word,
    output cvr_pkg::t_cell_word o_word
);

    cvr_pkg::t_cell_word r_word;
    cvr_pkg::t_cell_word n_word;

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] at;
    logic [61:0]        dv_sh;
    logic [62:0]        diff;
    logic               q_bit;

    // CORDIC step: floor shifts, direction from the sign of the residual
    always_comb begin
        dx    = i_word.y >>> i_step;
        dy    = i_word.x >>> i_step;
        at    = signed'({3'b000, cvr_pkg::atan_turn(i_step)});
        dv_sh = {i_word.dvsr, 29'd0};
        diff  = i_word.rem - {1'b0, dv_sh};
        q_bit = (i_word.rem >= {1'b0, dv_sh});

        n_word = i_word;
        if (!i_word.z[32]) begin
            n_word.x = i_word.x - dx;
            n_word.y = i_word.y + dy;
            n_word.z = i_word.z - at;
        end else begin
            n_word.x = i_word.x + dx;
            n_word.y = i_word.y - dy;
            n_word.z = i_word.z + at;
        end

        // restoring division, remainder shifted against a fixed divisor
        if (q_bit) begin
            n_word.rem = {diff[61:0], 1'b0};
        end else begin
            n_word.rem = {i_word.rem[61:0], 1'b0};
        end
        n_word.quo = {i_word.quo[28:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

FILE: rtl/cvr_resp.sv
// ----------------------------------------------------------------------------
// cvr_resp
// Response pipeline: trig rounding, forward rotation, 1D restitution impulse,
// back rotation, rounding and saturation of the four components.
// ----------------------------------------------------------------------------
module cvr_resp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cvr_pkg::t_cell_word i_word,
    input  logic [16:0]         i_restitution,
    output logic                o_done,
    output logic signed [31:0]  o_new_vel_a_x,
    output logic signed [31:0]  o_new_vel_a_y,
    output logic signed [31:0]  o_new_vel_b_x,
    output logic signed [31:0]  o_new_vel_b_y,
    output logic                o_saturated
);

    // stage valids
    logic [7:0] r_v;

    // stage 0: cos/sin in Q1.27, mass ratios
    logic signed [34:0] cf, sf;
    logic signed [29:0] n0_c, n0_s;
    logic [28:0]        n0_wb;
    logic signed [29:0] r0_c, r0_s;
    logic [28:0]        r0_wb, r0_wa;
    logic signed [31:0] r0_ax, r0_ay, r0_bx, r0_by;

    // stage 1: forward rotation products
    logic signed [61:0] r1_p [8];
    logic signed [29:0] r1_c, r1_s;
    logic [28:0]        r1_wb, r1_wa;

    // stage 2: rotated components
    logic signed [62:0] sum2 [4];
    logic signed [35:0] r2_r [4];
    logic signed [29:0] r2_c, r2_s;
    logic [28:0]        r2_wb, r2_wa;

    // stage 3: relative velocity times mass ratio
    logic signed [36:0] d3;
    logic signed [66:0] r3_pa, r3_pb;
    logic signed [35:0] r3_r [4];
    logic signed [29:0] r3_c, r3_s;

    // stage 4: times (1 + e)
    logic signed [66:0] t4a, t4b;
    logic signed [38:0] u4a, u4b;
    logic signed [18:0] g4;
    logic [16:0]        e4;
    logic signed [57:0] r4_ta, r4_tb;
    logic signed [35:0] r4_r [4];
    logic signed [29:0] r4_c, r4_s;

    // stage 5: impulse applied
    logic signed [57:0] t5a, t5b;
    logic signed [42:0] s5a, s5b;
    logic signed [37:0] r5_ray, r5_rby;
    logic signed [35:0] r5_rax, r5_rbx;
    logic signed [29:0] r5_c, r5_s;

    // stage 6: back rotation products
    logic signed [67:0] r6_p [8];

    // stage 7: rounding and clamp
    logic signed [68:0] sum7 [4];
    logic signed [41:0] res7 [4];
    logic signed [31:0] n7_v [4];
    logic               n7_sat;
    logic signed [31:0] r_out [4];
    logic               r_sat;

    // quadrant fold and rounding of the CORDIC result
    always_comb begin
        case (i_word.quad)
            2'd0:    begin cf = 35'(i_word.x);  sf = 35'(i_word.y);  end
            2'd1:    begin cf = -35'(i_word.y); sf = 35'(i_word.x);  end
            2'd2:    begin cf = -35'(i_word.x); sf = -35'(i_word.y); end
            default: begin cf = 35'(i_word.y);  sf = -35'(i_word.x); end
        endcase
        n0_c  = 30'((cf + 35'sd4) >>> 3);
        n0_s  = 30'((sf + 35'sd4) >>> 3);
        // both masses zero: one half each
        n0_wb = (i_word.dvsr == 33'd0) ? 29'd134217728 : i_word.quo[28:0];
    end

    // forward rotation sums
    always_comb begin
        sum2[0] = 63'(r1_p[0]) - 63'(r1_p[1]) + 63'sd67108864;
        sum2[1] = 63'(r1_p[2]) + 63'(r1_p[3]) + 63'sd67108864;
        sum2[2] = 63'(r1_p[4]) - 63'(r1_p[5]) + 63'sd67108864;
        sum2[3] = 63'(r1_p[6]) + 63'(r1_p[7]) + 63'sd67108864;
    end

    // impulse path
    always_comb begin
        d3  = 37'(r2_r[3]) - 37'(r2_r[1]);
        t4a = r3_pa + 67'sd134217728;
        t4b = r3_pb + 67'sd134217728;
        u4a = 39'(t4a >>> 28);
        u4b = 39'(t4b >>> 28);
        e4  = (i_restitution > cvr_pkg::RESTITUTION_MAX) ? cvr_pkg::RESTITUTION_MAX
                                                         : i_restitution;
        g4  = signed'(19'(18'd65536 + 18'(e4)));
        t5a = r4_ta + 58'sd32768;
        t5b = r4_tb + 58'sd32768;
        s5a = 43'(r4_r[1]) + 43'(t5a >>> 16);
        s5b = 43'(r4_r[3]) - 43'(t5b >>> 16);
    end

    // back rotation, rounding and clamp
    always_comb begin
        sum7[0] = 69'(r6_p[0]) + 69'(r6_p[1]) + 69'sd67108864;
        sum7[1] = 69'(r6_p[2]) - 69'(r6_p[3]) + 69'sd67108864;
        sum7[2] = 69'(r6_p[4]) + 69'(r6_p[5]) + 69'sd67108864;
        sum7[3] = 69'(r6_p[6]) - 69'(r6_p[7]) + 69'sd67108864;
        n7_sat  = 1'b0;
        for (int k = 0; k < 4; k++) begin
            res7[k] = 42'(sum7[k] >>> 27);
            if (res7[k] > 42'sd2147483647) begin
                n7_v[k] = 32'sh7FFFFFFF;
                n7_sat  = 1'b1;
            end else if (res7[k] < -42'sd2147483648) begin
                n7_v[k] = 32'sh80000000;
                n7_sat  = 1'b1;
            end else begin
                n7_v[k] = 32'(res7[k]);
            end
        end
    end

    // control: valid shift and flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 8'd0;
            r_sat <= 1'b0;
        end else begin
            r_v   <= {r_v[6:0], i_word.valid};
            r_sat <= r_v[6] & n7_sat;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r0_c  <= n0_c;
        r0_s  <= n0_s;
        r0_wb <= n0_wb;
        r0_wa <= 29'd268435456 - n0_wb;
        r0_ax <= i_word.ax;
        r0_ay <= i_word.ay;
        r0_bx <= i_word.bx;
        r0_by <= i_word.by;

        r1_p[0] <= r0_ax * r0_c;
        r1_p[1] <= r0_ay * r0_s;
        r1_p[2] <= r0_ax * r0_s;
        r1_p[3] <= r0_ay * r0_c;
        r1_p[4] <= r0_bx * r0_c;
        r1_p[5] <= r0_by * r0_s;
        r1_p[6] <= r0_bx * r0_s;
        r1_p[7] <= r0_by * r0_c;
        r1_c    <= r0_c;
        r1_s    <= r0_s;
        r1_wb   <= r0_wb;
        r1_wa   <= r0_wa;

        for (int k = 0; k < 4; k++) begin
            r2_r[k] <= 36'(sum2[k] >>> 27);
        end
        r2_c  <= r1_c;
        r2_s  <= r1_s;
        r2_wb <= r1_wb;
        r2_wa <= r1_wa;

        r3_pa <= d3 * signed'({1'b0, r2_wb});
        r3_pb <= d3 * signed'({1'b0, r2_wa});
        r3_r  <= r2_r;
        r3_c  <= r2_c;
        r3_s  <= r2_s;

        r4_ta <= u4a * g4;
        r4_tb <= u4b * g4;
        r4_r  <= r3_r;
        r4_c  <= r3_c;
        r4_s  <= r3_s;

        r5_ray <= 38'(s5a);
        r5_rby <= 38'(s5b);
        r5_rax <= r4_r[0];
        r5_rbx <= r4_r[2];
        r5_c   <= r4_c;
        r5_s   <= r4_s;

        r6_p[0] <= r5_rax * r5_c;
        r6_p[1] <= r5_ray * r5_s;
        r6_p[2] <= r5_ray * r5_c;
        r6_p[3] <= r5_rax * r5_s;
        r6_p[4] <= r5_rbx * r5_c;
        r6_p[5] <= r5_rby * r5_s;
        r6_p[6] <= r5_rby * r5_c;
        r6_p[7] <= r5_rbx * r5_s;

        r_out <= n7_v;
    end

    assign o_done        = r_v[7];
    assign o_new_vel_a_x = r_out[0];
    assign o_new_vel_a_y = r_out[1];
    assign o_new_vel_b_x = r_out[2];
    assign o_new_vel_b_y = r_out[3];
    assign o_saturated   = r_sat;

endmodule

FILE: rtl/collision_velocity_response_2d_unit.sv
// ----------------------------------------------------------------------------
// collision_velocity_response_2d_unit
// Velocity response of two colliding bodies in 2D, one pair per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present both velocities (Q15.16), both masses (Q16.16)
//   and the contact angle, and raise start. A word is taken at every edge
//   with start high; busy stays low, so a pair may enter every cycle.
//   Result channel: o_done is high for one cycle with the four new velocity
//   components and the saturation flag. There is no back-pressure: the
//   receiver must take every result when it appears.
//   Pipeline: a pair passes through 30 chained cells (one CORDIC step and
//   one quotient bit each) and 8 response stages, one register each.
//   Throughput is one pair per cycle, set by the fully pipelined chain.
//   Configuration: restitution is written through i_cfg_valid / o_cfg_ready
//   (always ready); the user must write it only while no pair is in flight,
//   which the block itself does not enforce. Values above one act as one.
//   Reset clears all valid bits; restitution returns to one (elastic).
// ----------------------------------------------------------------------------
module collision_velocity_response_2d_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic [31:0]        i_mass_a,
    input  logic [31:0]        i_mass_b,
    input  logic [15:0]        i_contact_angle,
    output logic               o_done,
    output logic signed [31:0] o_new_vel_a_x,
    output logic signed [31:0] o_new_vel_a_y,
    output logic signed [31:0] o_new_vel_b_x,
    output logic signed [31:0] o_new_vel_b_y,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [16:0]        i_cfg_data
);

    logic [16:0]         r_restitution;
    logic [32:0]         mass_sum;
    logic [31:0]         phase;
    cvr_pkg::t_cell_word w_entry;
    cvr_pkg::t_cell_word w [cvr_pkg::CORDIC_STEPS + 1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // restitution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= cvr_pkg::RESTITUTION_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_restitution <= i_cfg_data;
        end
    end

    // entry word: phase to 2^32 per turn, division set-up
    always_comb begin
        mass_sum = {1'b0, i_mass_a} + {1'b0, i_mass_b};
        phase    = 32'(i_contact_angle & 16'((1 << cvr_pkg::ANGLE_BITS) - 1))
                   << (32 - cvr_pkg::ANGLE_BITS);
        w_entry.valid = start && !busy;
        w_entry.quad  = phase[31:30];
        w_entry.x     = cvr_pkg::CORDIC_K;
        w_entry.y     = 34'sd0;
        w_entry.z     = signed'({3'b000, phase[29:0]});
        w_entry.rem   = (63'(i_mass_b) << 28) + 63'(mass_sum >> 1);
        w_entry.dvsr  = mass_sum;
        w_entry.quo   = 30'd0;
        w_entry.ax    = i_vel_a_x;
        w_entry.ay    = i_vel_a_y;
        w_entry.bx    = i_vel_b_x;
        w_entry.by    = i_vel_b_y;
    end

    assign w[0] = w_entry;

    // chain of cells
    for (genvar k = 0; k < cvr_pkg::CORDIC_STEPS; k++) begin : g_cell
        cvr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (5'(k)),
            .i_word  (w[k]),
            .o_word  (w[k+1])
        );
    end

    cvr_resp u_resp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (w[cvr_pkg::CORDIC_STEPS]),
        .i_restitution (r_restitution),
        .o_done        (o_done),
        .o_new_vel_a_x (o_new_vel_a_x),
        .o_new_vel_a_y (o_new_vel_a_y),
        .o_new_vel_b_x (o_new_vel_b_x),
        .o_new_vel_b_y (o_new_vel_b_y),
        .o_saturated   (o_saturated)
    );

    // every result traces back to a word taken a fixed latency earlier
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, cvr_pkg::LATENCY))
        else $error("result strobe without matching input word");

    // flag only travels with a result
    a_sat_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_done)
        else $error("saturation flag outside a result");

    // a clamped result shows a range limit in some component
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |->
            (o_new_vel_a_x == 32'sh7FFFFFFF || o_new_vel_a_x == 32'sh80000000 ||
             o_new_vel_a_y == 32'sh7FFFFFFF || o_new_vel_a_y == 32'sh80000000 ||
             o_new_vel_b_x == 32'sh7FFFFFFF || o_new_vel_b_x == 32'sh80000000 ||
             o_new_vel_b_y == 32'sh7FFFFFFF || o_new_vel_b_y == 32'sh80000000))
        else $error("saturation flag without a clamped component");

endmodule
